FILE: hw/rtl/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int BYTE_W         = 8;
    localparam int CP_W           = 21;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Lead byte classes: 0..3 give the continuation bytes that follow
    localparam logic [2:0] CLS_ASCII   = 3'd0;
    localparam logic [2:0] CLS_INVALID = 3'd4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;

    // One queued decode result: one or two code points
    typedef struct packed {
        cp_t  cp0;
        cp_t  cp1;
        logic two;
        logic last;
    } entry_t;

    function automatic logic [2:0] lead_class(input byte_t b);
        logic [2:0] cls;
        begin
            priority if (b[7] == 1'b0)        cls = CLS_ASCII;
            else if (b[7:5] == 3'b110)        cls = 3'd1;
            else if (b[7:4] == 4'b1110)       cls = 3'd2;
            else if (b[7:3] == 5'b11110)      cls = 3'd3;
            else                              cls = CLS_INVALID;
            return cls;
        end
    endfunction

    // Join a lead byte and k continuation bytes into a code point
    function automatic cp_t assemble(input byte_t b0, input byte_t b1,
                                     input byte_t b2, input byte_t b3,
                                     input logic [1:0] k);
        cp_t cp;
        begin
            unique case (k)
                2'd0:    cp = {13'd0, b0};
                2'd1:    cp = {10'd0, b0[4:0], b1[5:0]};
                2'd2:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            endcase
            return cp;
        end
    endfunction

endpackage

FILE: hw/rtl/u8d_front.sv
`timescale 1ns / 1ps

module u8d_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  u8d_pkg::byte_t  s_tdata,
    input  logic            s_tlast,
    input  logic            q_full,
    output logic            q_push,
    output u8d_pkg::entry_t q_entry
);
    import u8d_pkg::*;

    byte_t       pend_reg [3];
    logic [1:0]  pc_reg, pc_next;
    logic [1:0]  bn_reg, bn_next;

    logic        accept;
    byte_t       tb [7];
    logic [2:0]  n;
    logic [2:0]  cls;
    logic [2:0]  dcls;
    logic [2:0]  nxt;
    logic [1:0]  tcnt;
    logic [1:0]  st0, st1;
    logic [1:0]  k0, k1;
    logic [2:0]  w0, w1;
    cp_t         cp_a, cp_b, cp_seq;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign cls      = lead_class(s_tdata);
    assign n        = {1'b0, pc_reg} + 3'd1;

    // Line up held bytes and the incoming byte, zero padded past the end
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            tb[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < pc_reg)
            begin
                tb[i] = pend_reg[i];
            end
        end
        tb[{1'b0, pc_reg}] = s_tdata;
    end

    // Scan the tail of a finished string for complete sequences
    always_comb
    begin
        nxt  = 3'd0;
        tcnt = 2'd0;
        st0  = 2'd0;
        st1  = 2'd0;
        k0   = 2'd0;
        k1   = 2'd0;
        dcls = CLS_ASCII;
        for (int j = 0; j < 4; j++)
        begin
            if ((3'(j) < n) && (3'(j) == nxt))
            begin
                dcls = lead_class(tb[j]);
                if ((dcls == CLS_INVALID) || ((3'(j) + dcls) >= n))
                begin
                    nxt = 3'(j) + 3'd1;
                end
                else
                begin
                    if (tcnt == 2'd0)
                    begin
                        st0 = 2'(j);
                        k0  = dcls[1:0];
                    end
                    else if (tcnt == 2'd1)
                    begin
                        st1 = 2'(j);
                        k1  = dcls[1:0];
                    end
                    if (tcnt != 2'd2)
                    begin
                        tcnt = tcnt + 2'd1;
                    end
                    nxt = 3'(j) + dcls + 3'd1;
                end
            end
        end
    end

    assign w0     = {1'b0, st0};
    assign w1     = {1'b0, st1};
    assign cp_a   = assemble(tb[w0], tb[w0 + 3'd1], tb[w0 + 3'd2], tb[w0 + 3'd3], k0);
    assign cp_b   = assemble(tb[w1], tb[w1 + 3'd1], tb[w1 + 3'd2], tb[w1 + 3'd3], k1);
    assign cp_seq = assemble(tb[0], tb[1], tb[2], tb[3], bn_reg);

    // Classify the byte and build the queue entry
    always_comb
    begin
        q_push       = 1'b0;
        q_entry.cp0  = cp_seq;
        q_entry.cp1  = cp_b;
        q_entry.two  = 1'b0;
        q_entry.last = 1'b0;
        pc_next      = pc_reg;
        bn_next      = bn_reg;
        if (s_tlast)
        begin
            q_push       = accept && (tcnt != 2'd0);
            q_entry.cp0  = cp_a;
            q_entry.two  = (tcnt == 2'd2);
            q_entry.last = 1'b1;
            pc_next      = 2'd0;
            bn_next      = 2'd0;
        end
        else if (pc_reg == 2'd0)
        begin
            q_entry.cp0 = {13'd0, s_tdata};
            q_push      = accept && (cls == CLS_ASCII);
            if ((cls != CLS_ASCII) && (cls != CLS_INVALID))
            begin
                pc_next = 2'd1;
                bn_next = cls[1:0];
            end
        end
        else if (pc_reg >= bn_reg)
        begin
            q_push  = accept;
            pc_next = 2'd0;
            bn_next = 2'd0;
        end
        else
        begin
            pc_next = pc_reg + 2'd1;
        end
    end

    // Advance sequence state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 2'd0;
            bn_reg <= 2'd0;
        end
        else if (accept)
        begin
            pc_reg <= pc_next;
            bn_reg <= bn_next;
        end
    end

    // Hold the lead and continuation bytes of the open sequence
    always_ff @(posedge clk)
    begin
        if (accept && !s_tlast && (pc_next != 2'd0) && (pc_next != pc_reg))
        begin
            pend_reg[pc_reg] <= s_tdata;
        end
    end

endmodule

FILE: hw/rtl/u8d_queue.sv
`timescale 1ns / 1ps

module u8d_queue #(
    parameter int DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  u8d_pkg::entry_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output u8d_pkg::entry_t rd_data
);
    import u8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Wrap pointers at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/u8d_back.sv
`timescale 1ns / 1ps

module u8d_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  u8d_pkg::entry_t               q_entry,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8d_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import u8d_pkg::*;

    logic  valid_reg, valid_next;
    logic  sel_reg, sel_next;
    cp_t   cp_reg, cp_next;
    logic  last_reg, last_next;
    logic  load;

    assign load     = q_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_TDATA_W - CP_W)'(0), cp_reg};
    assign m_tlast  = last_reg;

    // Emit the first code point, then the second if the entry has one
    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        cp_next    = cp_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            if (sel_reg)
            begin
                cp_next   = q_entry.cp1;
                last_next = q_entry.last;
                sel_next  = 1'b0;
                q_pop     = 1'b1;
            end
            else
            begin
                cp_next   = q_entry.cp0;
                last_next = q_entry.last && !q_entry.two;
                sel_next  = q_entry.two;
                q_pop     = !q_entry.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // Hold output payload until the transfer
    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        last_reg <= last_next;
    end

endmodule

FILE: hw/rtl/utf8_codepoint_decoder.sv
// A byte that completes a code point is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; one code point per cycle leaves the
// output register while m_tready is high. A final byte may yield two code points in one entry,
// sent out in turn; a queue (4 entries by default) absorbs that and output stalls.
// Reset (rst_n low, asynchronous) drops any open sequence and empties queue and output.
`timescale 1ns / 1ps

module utf8_codepoint_decoder #(
    parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u8d_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,   // string_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8d_pkg::M_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic                          m_tlast    // end_of_run
);
    import u8d_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    entry_t push_entry;
    entry_t head_entry;

    u8d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (push_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (head_entry)
    );

    u8d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/u8d_checker.sv
`timescale 1ns / 1ps

module u8d_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [u8d_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import u8d_pkg::*;

    // Output stays empty while reset is held
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // A stalled transfer keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // Code points never exceed 21 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:CP_W] == '0))
        else $error("code point pad bits set");

    // Input backpressure only comes from a full queue, which implies pending output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with idle output");

endmodule

bind utf8_codepoint_decoder u8d_checker u_chk (.*);
